[rtl/ti_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the breakpoint table interpolator.
package ti_pkg;

    localparam int VAL_W      = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int CLAMP_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DCNT_W     = $clog2(VAL_W + 1);

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'b1;

    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

    typedef struct packed {
        logic             is_eval;
        logic             load_ok;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] tval;
        logic [VAL_W-1:0] fval;
    } ti_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN,
        S_DONE
    } ti_state_t;

endpackage

[rtl/table_interpolator.sv]
`timescale 1ns / 1ps
// Top level of the piecewise linear breakpoint table interpolator.
//
// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid / in_stall | action, entry_index, entry_time, entry_value,
//         |                     | query_time
// out     | out_valid/out_stall | result_value, segment_index, clamp_kind
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load item is written to the table from the idle state. A lookup checks the first breakpoint
// (clamped below) and then the last (clamped above); inside, it scans the breakpoints between
// them, one table read per cycle. Linear mode adds a multiply, a divider start, the 32-step
// radix-2 divider and a final add.
// Reset sets linear mode and a count of one; table contents are undefined until loaded.
// A two-entry queue keeps accepting items, until it is full, while the back end works or the result is stalled.
module table_interpolator #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [ti_pkg::IDX_W-1:0]      entry_index,
    input  logic [ti_pkg::VAL_W-1:0]      entry_time,
    input  logic [ti_pkg::VAL_W-1:0]      entry_value,
    input  logic [ti_pkg::VAL_W-1:0]      query_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ti_pkg::VAL_W-1:0]      result_value,
    output logic [ti_pkg::IDX_W-1:0]      segment_index,
    output logic [ti_pkg::CLAMP_W-1:0]    clamp_kind,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ti_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ti_pkg::*;

    logic             linear_reg;
    logic [CNT_W-1:0] count_reg;
    logic             q_valid;
    ti_item_t         q_item;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_reg <= 1'b1;
            count_reg  <= CNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINEAR: linear_reg <= cfg_data[0];
                CFG_COUNT:  count_reg  <= cfg_data[CNT_W-1:0];
                default:    linear_reg <= linear_reg;
            endcase
        end
    end

    ti_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .entry_index (entry_index),
        .entry_time  (entry_time),
        .entry_value (entry_value),
        .query_time  (query_time),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    ti_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .interp_linear (linear_reg),
        .entry_count   (count_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .segment_index (segment_index),
        .clamp_kind    (clamp_kind)
    );

endmodule

[rtl/ti_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ti_front.sv]
`timescale 1ns / 1ps
// Input front end: classifies items and buffers them in a two-entry queue.
module ti_front #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [ti_pkg::IDX_W-1:0] entry_index,
    input  logic [ti_pkg::VAL_W-1:0] entry_time,
    input  logic [ti_pkg::VAL_W-1:0] entry_value,
    input  logic [ti_pkg::VAL_W-1:0] query_time,
    output logic                    q_valid,
    output ti_pkg::ti_item_t        q_item,
    input  logic                    q_pop
);
    import ti_pkg::*;

    ti_item_t          slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    ti_item_t          new_item;
    logic              push;

    assign in_stall = (count_reg == QCNT_W'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.is_eval = (action == ACT_EVAL);
        new_item.load_ok = (int'(entry_index) < TABLE_DEPTH);
        new_item.index   = entry_index;
        new_item.tval    = (action == ACT_EVAL) ? query_time : entry_time;
        new_item.fval    = entry_value;
    end

    always_comb
    begin
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> q_valid)
        else $error("pushed item not visible at queue head");

endmodule

[rtl/ti_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module ti_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ti_pkg::PROD_W-1:0] dividend,
    input  logic [ti_pkg::VAL_W-1:0]  divisor,
    output logic                     done,
    output logic [ti_pkg::VAL_W-1:0]  quotient
);
    import ti_pkg::*;

    logic [VAL_W:0]    rem_reg;
    logic [VAL_W-1:0]  low_reg;
    logic [VAL_W-1:0]  div_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [VAL_W:0]    shifted;
    logic [VAL_W+1:0]  diff;
    logic              fits;

    // quotient is known to fit 32 bits, so the partial remainder stays below the divisor
    assign shifted  = {rem_reg[VAL_W-1:0], low_reg[VAL_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, div_reg};
    assign fits     = !diff[VAL_W+1];
    assign done     = done_reg;
    assign quotient = low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DCNT_W'(VAL_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[PROD_W-1:VAL_W]};
            low_reg <= dividend[VAL_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[VAL_W:0] : shifted;
            low_reg <= {low_reg[VAL_W-2:0], fits};
        end
    end

endmodule

[rtl/ti_back.sv]
`timescale 1ns / 1ps
// Execution back end: table writes, clamp checks, segment scan and interpolation.
module ti_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  ti_pkg::ti_item_t           q_item,
    output logic                       q_pop,
    input  logic                       interp_linear,
    input  logic [ti_pkg::CNT_W-1:0]   entry_count,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [ti_pkg::VAL_W-1:0]   result_value,
    output logic [ti_pkg::IDX_W-1:0]   segment_index,
    output logic [ti_pkg::CLAMP_W-1:0] clamp_kind
);
    import ti_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int RAM_W = 2 * VAL_W;

    ti_state_t          state_reg;
    ti_state_t          state_next;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [RAM_W-1:0]   ram_rd_data;
    logic signed [VAL_W-1:0] rd_t;
    logic signed [VAL_W-1:0] rd_f;

    logic [AW-1:0]      last_idx;
    logic               le_first;
    logic               ge_last;
    logic               advance;
    logic               out_free;
    logic               out_load;
    logic               div_start;
    logic               div_done;
    logic [VAL_W-1:0]   div_quo;

    logic signed [VAL_W-1:0] q_reg;
    logic signed [VAL_W-1:0] t0_reg;
    logic signed [VAL_W-1:0] f0_reg;
    logic [AW-1:0]      hi_idx_reg;
    logic [VAL_W-1:0]   dfm_reg;
    logic [VAL_W-1:0]   dq_reg;
    logic [VAL_W-1:0]   dt_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VAL_W-1:0]   res_val_reg;
    logic [AW-1:0]      res_seg_reg;
    logic [CLAMP_W-1:0] res_kind_reg;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [IDX_W-1:0]   out_seg_reg;
    logic [CLAMP_W-1:0] out_kind_reg;

    logic signed [VAL_W:0] df_w;
    logic signed [VAL_W:0] dq_w;
    logic signed [VAL_W:0] dt_w;
    logic signed [VAL_W:0] dfm_w;

    ti_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(q_item.index)),
        .wr_data ({q_item.tval, q_item.fval}),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign rd_t = $signed(ram_rd_data[RAM_W-1:VAL_W]);
    assign rd_f = $signed(ram_rd_data[VAL_W-1:0]);

    // zero count acts as one, large counts saturate at the table depth
    always_comb
    begin
        if (entry_count == '0)
        begin
            last_idx = '0;
        end
        else if (int'(entry_count) > TABLE_DEPTH)
        begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = AW'(int'(entry_count) - 1);
        end
    end

    assign le_first = (q_reg <= rd_t);
    assign ge_last  = (q_reg >= rd_t);
    assign advance  = (hi_idx_reg != last_idx) && (q_reg > rd_t);
    assign out_free = !out_valid_reg || !out_stall;

    assign df_w  = {rd_f[VAL_W-1], rd_f} - {f0_reg[VAL_W-1], f0_reg};
    assign dq_w  = {q_reg[VAL_W-1], q_reg} - {t0_reg[VAL_W-1], t0_reg};
    assign dt_w  = {rd_t[VAL_W-1], rd_t} - {t0_reg[VAL_W-1], t0_reg};
    assign dfm_w = df_w[VAL_W] ? -df_w : df_w;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_item.is_eval)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:  state_next = le_first ? S_DONE : S_LAST;
            S_LAST:   state_next = ge_last ? S_DONE : S_SCAN;
            S_SCAN:
            begin
                if (advance)
                begin
                    state_next = S_SCAN;
                end
                else if (interp_linear)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:    state_next = div_done ? S_FIN : S_DIV;
            S_FIN:    state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_addr = '0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                q_pop     = q_valid;
                ram_wr_en = q_valid && !q_item.is_eval && q_item.load_ok;
            end
            S_FIRST:  ram_rd_addr = last_idx;
            S_LAST:   ram_rd_addr = AW'(1);
            S_SCAN:   ram_rd_addr = hi_idx_reg + 1'b1;
            S_DSTART: div_start = 1'b1;
            S_DONE:   out_load = out_free;
            default:  ram_rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                q_reg <= $signed(q_item.tval);
            end
            S_FIRST:
            begin
                t0_reg <= rd_t;
                f0_reg <= rd_f;
                if (le_first)
                begin
                    res_val_reg  <= rd_f;
                    res_seg_reg  <= '0;
                    res_kind_reg <= CLAMP_LOW;
                end
            end
            S_LAST:
            begin
                hi_idx_reg <= AW'(1);
                if (ge_last)
                begin
                    res_val_reg  <= rd_f;
                    res_seg_reg  <= last_idx;
                    res_kind_reg <= CLAMP_HIGH;
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    t0_reg     <= rd_t;
                    f0_reg     <= rd_f;
                    hi_idx_reg <= hi_idx_reg + 1'b1;
                end
                else
                begin
                    res_val_reg  <= f0_reg;
                    res_seg_reg  <= hi_idx_reg - 1'b1;
                    res_kind_reg <= CLAMP_NONE;
                    dfm_reg      <= dfm_w[VAL_W-1:0];
                    dq_reg       <= dq_w[VAL_W-1:0];
                    dt_reg       <= dt_w[VAL_W-1:0];
                    neg_reg      <= df_w[VAL_W];
                end
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(dfm_reg) * PROD_W'(dq_reg);
            end
            S_FIN:
            begin
                // quotient never exceeds |f1 - f0|, so the sum stays in range
                res_val_reg <= neg_reg ? (f0_reg - div_quo) : (f0_reg + div_quo);
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_value_reg <= res_val_reg;
                    out_seg_reg   <= IDX_W'(res_seg_reg);
                    out_kind_reg  <= res_kind_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = out_value_reg;
    assign segment_index = out_seg_reg;
    assign clamp_kind    = out_kind_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished while sequencer not waiting");

    a_inside_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_kind_reg == CLAMP_NONE) |-> (res_seg_reg < last_idx))
        else $error("inside segment index past last breakpoint");

endmodule
